[hdl/mcf_pkg.sv]
// Shared types and constants for the message chunk framer.
// Used by mcf_ctrl, mcf_datapath and message_chunk_framer; depends on nothing.
`timescale 1ns / 1ps

package mcf_pkg;

  localparam int FRAME_BYTES = 13;
  localparam int HEAD_BYTES  = 3;

  localparam logic [3:0] FRAME_LAST_POS = 4'(FRAME_BYTES - 1);
  localparam logic [3:0] HEAD_LEN       = 4'(HEAD_BYTES);

  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_CONT  = 8'h63;  // 'c'
  localparam logic [7:0] CHAR_SHORT = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_END   = 8'h65;  // 'e', also the pad byte
  localparam logic [7:0] CHAR_ZERO  = 8'd48;  // '0'

  // Which frame the datapath is told to build.
  typedef enum logic [1:0] {
    KIND_CONT  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_EMPTY = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic        hold;      // capture the incoming data byte
    logic        start;     // begin a frame of the given kind
    frame_kind_t kind;
    logic        run_last;  // flag the frame's last byte as the item's last result
    logic        clr_fill;  // chunk has been handed to the frame builder
    logic        wr_byte;   // append the held byte to the chunk
  } mcf_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic frame_done;  // thirteenth byte moved into the output register
  } mcf_status_t;

endpackage

[hdl/mcf_datapath.sv]
// Datapath of the message chunk framer: chunk buffer, fill count, frame
// builder and output register. Depends on mcf_pkg.
`timescale 1ns / 1ps

module mcf_datapath #(
  parameter int CHUNK_BYTES = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mcf_pkg::mcf_cmd_t   cmd,
  output mcf_pkg::mcf_status_t status,
  input  logic [7:0]          in_byte,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_frame_end,
  output logic                out_run_last
);

  localparam int IDX_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam logic [3:0] CHUNK_FULL = 4'(CHUNK_BYTES);

  logic [7:0] store_r [CHUNK_BYTES];
  logic [3:0] fill_r;
  logic [7:0] hold_r;

  logic       busy_r;
  logic [3:0] pos_r;
  logic [7:0] code_r;
  logic [7:0] digit_r;
  logic [3:0] n_r;
  logic       rl_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_end_r;
  logic       out_rl_r;

  logic       advance;
  logic       last_pos;
  logic [3:0] payload_idx;
  logic [7:0] byte_sel;
  logic [7:0] code_nxt;
  logic [7:0] digit_nxt;
  logic [3:0] n_nxt;

  assign advance     = busy_r & (~out_valid_r | out_ready);
  assign last_pos    = (pos_r == mcf_pkg::FRAME_LAST_POS);
  assign payload_idx = pos_r - mcf_pkg::HEAD_LEN;

  always_comb begin
    if (pos_r == 4'd0) begin
      byte_sel = mcf_pkg::CHAR_SLASH;
    end else if (pos_r == 4'd1) begin
      byte_sel = code_r;
    end else if (pos_r == 4'd2) begin
      byte_sel = digit_r;
    end else if (payload_idx < n_r) begin
      byte_sel = store_r[payload_idx[IDX_W-1:0]];
    end else begin
      byte_sel = mcf_pkg::CHAR_END;
    end
  end

  // Header and payload length of the frame about to start.
  always_comb begin
    case (cmd.kind)
      mcf_pkg::KIND_CONT: begin
        code_nxt  = mcf_pkg::CHAR_CONT;
        digit_nxt = mcf_pkg::CHAR_ZERO;
        n_nxt     = CHUNK_FULL;
      end
      mcf_pkg::KIND_FINAL: begin
        if (fill_r == CHUNK_FULL) begin
          code_nxt  = mcf_pkg::CHAR_END;
          digit_nxt = mcf_pkg::CHAR_ZERO;
          n_nxt     = CHUNK_FULL;
        end else begin
          code_nxt  = mcf_pkg::CHAR_SHORT;
          digit_nxt = mcf_pkg::CHAR_ZERO + {4'b0000, fill_r};
          n_nxt     = fill_r;
        end
      end
      default: begin
        code_nxt  = mcf_pkg::CHAR_SHORT;
        digit_nxt = mcf_pkg::CHAR_ZERO;
        n_nxt     = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 4'd0;
      busy_r      <= 1'b0;
      pos_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_fill) begin
        fill_r <= 4'd0;
      end else if (cmd.wr_byte) begin
        fill_r <= fill_r + 4'd1;
      end

      if (cmd.start) begin
        busy_r <= 1'b1;
        pos_r  <= 4'd0;
      end else if (advance) begin
        pos_r <= pos_r + 4'd1;
        if (last_pos) begin
          busy_r <= 1'b0;
        end
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      hold_r <= in_byte;
    end
    if (cmd.wr_byte) begin
      store_r[fill_r[IDX_W-1:0]] <= hold_r;
    end
    if (cmd.start) begin
      code_r  <= code_nxt;
      digit_r <= digit_nxt;
      n_r     <= n_nxt;
      rl_r    <= cmd.run_last;
    end
    if (advance) begin
      out_byte_r <= byte_sel;
      out_end_r  <= last_pos;
      out_rl_r   <= last_pos & rl_r;
    end
  end

  assign status.fill_zero  = (fill_r == 4'd0);
  assign status.fill_full  = (fill_r == CHUNK_FULL);
  assign status.frame_done = advance & last_pos;

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_end_r;
  assign out_run_last  = out_rl_r;

endmodule

[hdl/mcf_ctrl.sv]
// Controller of the message chunk framer: sequences the frames caused by
// one input item. Depends on mcf_pkg.
`timescale 1ns / 1ps

module mcf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  input  logic                 in_empty,
  output logic                 in_ready,
  input  mcf_pkg::mcf_status_t status,
  output mcf_pkg::mcf_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_A_RUN   = 3'd1;
  localparam logic [2:0] S_WRITE   = 3'd2;
  localparam logic [2:0] S_B_START = 3'd3;
  localparam logic [2:0] S_B_RUN   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       last_r;
  logic       empty_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.kind  = mcf_pkg::KIND_EMPTY;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.hold = 1'b1;
          if (in_empty) begin
            if (!status.fill_zero) begin
              // Close the pending bytes as their message's final chunk first.
              cmd.start    = 1'b1;
              cmd.kind     = mcf_pkg::KIND_FINAL;
              cmd.clr_fill = 1'b1;
              state_nxt    = S_A_RUN;
            end else begin
              state_nxt = S_B_START;
            end
          end else if (status.fill_full) begin
            // More data follows the full chunk, so it goes out as a continuation.
            cmd.start    = 1'b1;
            cmd.kind     = mcf_pkg::KIND_CONT;
            cmd.run_last = ~in_last;
            cmd.clr_fill = 1'b1;
            state_nxt    = S_A_RUN;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_A_RUN: begin
        if (status.frame_done) begin
          state_nxt = empty_r ? S_B_START : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_byte = 1'b1;
        state_nxt   = last_r ? S_B_START : S_IDLE;
      end
      S_B_START: begin
        cmd.start    = 1'b1;
        cmd.kind     = empty_r ? mcf_pkg::KIND_EMPTY : mcf_pkg::KIND_FINAL;
        cmd.run_last = 1'b1;
        cmd.clr_fill = 1'b1;
        state_nxt    = S_B_RUN;
      end
      S_B_RUN: begin
        if (status.frame_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) begin
        last_r  <= in_last;
        empty_r <= in_empty;
      end
    end
  end

endmodule

[hdl/message_chunk_framer.sv]
// Top level of the message chunk framer: joins the controller and datapath.
// Depends on mcf_pkg, mcf_ctrl and mcf_datapath.
`timescale 1ns / 1ps

// The framer takes a message one byte per item and emits it as 13-byte frames,
// one frame byte per output item. Each frame is '/', a code byte, a digit byte
// and a 10-byte payload area. A chunk of CHUNK_BYTES bytes that is followed by
// more data goes out as '/','c','0'; a final full chunk as '/','e','0'; a
// shorter final chunk of k bytes, and an empty message, as '/','a','0'+k.
// Payload positions past the chunk bytes hold 'e'. A full chunk is held until
// the next item shows whether the message goes on. An item with empty_message
// set first closes any pending bytes as a final frame, then sends the empty
// frame. An item that only buffers its byte passes through S_WRITE. Every
// frame goes out one byte per cycle from the single frame builder while the
// output side does not stall; a final frame after a last byte is set up in
// its own state first. At most two frames (26 items) follow one input
// item, and the next item is taken once the frame builder has moved the last
// byte into the output register, even if that byte is still waiting there.
module message_chunk_framer #(
  parameter int CHUNK_BYTES = 10
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last
  input  logic       in_tuser,   // [0] empty_message

  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] frame_byte
  output logic       out_tlast,  // frame_end
  output logic       out_tuser   // [0] run_last
);

  mcf_pkg::mcf_cmd_t    cmd;
  mcf_pkg::mcf_status_t status;

  // The controller decides, per item, which frames go out and when the byte
  // is appended; the datapath owns all storage and the output register.
  mcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_empty (in_tuser),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mcf_datapath #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_byte       (in_tdata),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_byte      (out_tdata),
    .out_frame_end (out_tlast),
    .out_run_last  (out_tuser)
  );

endmodule

[sim/tb_message_chunk_framer.sv]
// Self-checking testbench for message_chunk_framer: directed table plus random messages,
// checked item by item against a frame predictor. Depends on mcf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_message_chunk_framer;

  localparam int CHUNK_BYTES  = 10;
  localparam int RANDOM_ITEMS = 380;
  localparam int HOLD_CYCLES  = 400;
  localparam int TIMEOUT_NS   = 10_000_000;

  // One output item of the framer as the predictor builds it.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       run_last;
  } frame_res_t;

  // One row of the directed table. A nonzero code means the single frame this
  // row causes is typed in here instead of taken from the predictor.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic [7:0] code;
    logic [7:0] digit;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  // Predictor state: bytes of the chunk not yet framed and how many there are.
  logic [7:0] pend_bytes [CHUNK_BYTES];
  int         pend_cnt;

  frame_res_t new_frames[$];    // results of the item being predicted
  frame_res_t frame_exp_q[$];   // results still owed by the block
  dir_row_t   dir_tab[$];

  int  err_cnt     = 0;
  int  items_sent  = 0;
  int  msgs_sent   = 0;
  int  frames_seen = 0;
  int  bytes_seen  = 0;
  int  holds_done  = 0;
  bit  no_idle     = 1'b0;
  bit  hold_req    = 1'b0;

  message_chunk_framer #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still owed", $time, frame_exp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Appends one 13-byte frame; the payload takes n pending bytes, the rest is pad.
  function automatic void emit_frame(logic [7:0] code, logic [7:0] digit, int n);
    frame_res_t r;
    for (int i = 0; i < mcf_pkg::FRAME_BYTES; i++) begin
      if (i == 0) r.frame_byte = mcf_pkg::CHAR_SLASH;
      else if (i == 1) r.frame_byte = code;
      else if (i == 2) r.frame_byte = digit;
      else if (i - mcf_pkg::HEAD_BYTES < n) r.frame_byte = pend_bytes[i - mcf_pkg::HEAD_BYTES];
      else r.frame_byte = mcf_pkg::CHAR_END;
      r.frame_end = (i == mcf_pkg::FRAME_BYTES - 1);
      r.run_last  = 1'b0;
      new_frames.push_back(r);
    end
  endfunction

  // Closes the pending bytes as the final chunk of their message.
  function automatic void close_chunk();
    if (pend_cnt >= CHUNK_BYTES)
      emit_frame(mcf_pkg::CHAR_END, mcf_pkg::CHAR_ZERO, CHUNK_BYTES);
    else
      emit_frame(mcf_pkg::CHAR_SHORT, mcf_pkg::CHAR_ZERO + 8'(pend_cnt), pend_cnt);
    pend_cnt = 0;
  endfunction

  // Works out the frame bytes that one accepted input item causes.
  function automatic void predict_frames(logic [7:0] d, logic l, logic e);
    frame_res_t r;
    if (e) begin
      if (pend_cnt > 0) close_chunk();
      emit_frame(mcf_pkg::CHAR_SHORT, mcf_pkg::CHAR_ZERO, 0);
    end else begin
      // A full chunk waits for the next byte to learn that more data follows.
      if (pend_cnt >= CHUNK_BYTES) begin
        emit_frame(mcf_pkg::CHAR_CONT, mcf_pkg::CHAR_ZERO, CHUNK_BYTES);
        pend_cnt = 0;
      end
      pend_bytes[pend_cnt] = d;
      pend_cnt++;
      if (l) close_chunk();
    end
    if (new_frames.size() > 0) begin
      r = new_frames.pop_back();
      r.run_last = 1'b1;
      new_frames.push_back(r);
    end
  endfunction

  // A hand-written short frame: digit '0' gives all pad, digit '1' carries data.
  function automatic void push_typed(logic [7:0] code, logic [7:0] digit, logic [7:0] d);
    frame_res_t r;
    for (int i = 0; i < mcf_pkg::FRAME_BYTES; i++) begin
      if (i == 0) r.frame_byte = mcf_pkg::CHAR_SLASH;
      else if (i == 1) r.frame_byte = code;
      else if (i == 2) r.frame_byte = digit;
      else if (i - mcf_pkg::HEAD_BYTES < int'(digit - mcf_pkg::CHAR_ZERO)) r.frame_byte = d;
      else r.frame_byte = mcf_pkg::CHAR_END;
      r.frame_end = (i == mcf_pkg::FRAME_BYTES - 1);
      r.run_last  = (i == mcf_pkg::FRAME_BYTES - 1);
      frame_exp_q.push_back(r);
    end
  endfunction

  function automatic void add_row(logic [7:0] d, logic l, logic e,
                                  logic [7:0] code, logic [7:0] digit);
    dir_row_t row;
    row.data  = d;
    row.last  = l;
    row.empty = e;
    row.code  = code;
    row.digit = digit;
    dir_tab.push_back(row);
  endfunction

  // Offers one item after a random gap and returns at the edge that accepts it.
  // Valid is left high so that a back-to-back item never toggles it.
  task automatic send_item(input logic [7:0] d, input logic l, input logic e,
                           input logic [7:0] code, input logic [7:0] digit);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_frames(d, l, e);
    if (code != 8'h00) begin
      new_frames.delete();
      push_typed(code, digit, d);
    end else begin
      while (new_frames.size() > 0) frame_exp_q.push_back(new_frames.pop_front());
    end
    in_tdata  <= d;
    in_tlast  <= l;
    in_tuser  <= e;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering and waits until every owed result has come.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (frame_exp_q.size() != 0) @(posedge clk);
    repeat (2 * mcf_pkg::FRAME_BYTES) @(posedge clk);
  endtask

  // Receiver: a random stall before each output item, and one long hold-off
  // on request so that the framer backs up into its input.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Every accepted output item is compared with the oldest owed result.
  always @(posedge clk) begin : check_out
    frame_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_exp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected item byte=%h end=%b run_last=%b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        want = frame_exp_q.pop_front();
        if (out_tdata !== want.frame_byte) begin
          err_cnt++;
          $display("%0t: frame_byte expected %h actual %h", $time, want.frame_byte, out_tdata);
        end
        if (out_tlast !== want.frame_end) begin
          err_cnt++;
          $display("%0t: frame_end expected %b actual %b", $time, want.frame_end, out_tlast);
        end
        if (out_tuser !== want.run_last) begin
          err_cnt++;
          $display("%0t: run_last expected %b actual %b", $time, want.run_last, out_tuser);
        end
      end
      bytes_seen++;
      if (out_tlast) frames_seen++;
    end
  end

  initial begin
    int  len;
    int  n;
    int  dir_items;
    bit  cut;
    bit  hold_issued;
    bit  paused;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    in_tuser  <= 1'b0;
    pend_cnt    = 0;
    hold_issued = 1'b0;
    paused      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message right after reset; data and last must be ignored.
    add_row(8'hFF, 1'b1, 1'b1, mcf_pkg::CHAR_SHORT, mcf_pkg::CHAR_ZERO);
    // One-byte messages at both byte extremes.
    add_row(8'h00, 1'b1, 1'b0, mcf_pkg::CHAR_SHORT, mcf_pkg::CHAR_ZERO + 8'd1);
    add_row(8'hFF, 1'b1, 1'b0, mcf_pkg::CHAR_SHORT, mcf_pkg::CHAR_ZERO + 8'd1);
    // A full chunk followed by a last byte: continue frame plus one-byte frame.
    for (int i = 0; i < CHUNK_BYTES; i++) add_row(8'(8'h11 * i), 1'b0, 1'b0, 8'h00, 8'h00);
    add_row(8'h80, 1'b1, 1'b0, 8'h00, 8'h00);
    // A full chunk closed by an empty message: end frame, then the empty frame.
    for (int i = 0; i < CHUNK_BYTES; i++) add_row(8'(8'hF0 - i), 1'b0, 1'b0, 8'h00, 8'h00);
    add_row(8'h5A, 1'b0, 1'b1, 8'h00, 8'h00);

    foreach (dir_tab[i])
      send_item(dir_tab[i].data, dir_tab[i].last, dir_tab[i].empty,
                dir_tab[i].code, dir_tab[i].digit);
    dir_items = items_sent;
    wait_drained();

    // Random part: mostly whole messages of varied length, some noise.
    while (items_sent < dir_items + RANDOM_ITEMS) begin
      if (!hold_issued && items_sent >= dir_items + 150) begin
        hold_issued = 1'b1;
        hold_req    = 1'b1;
      end
      if (!paused && items_sent >= dir_items + 300) begin
        paused = 1'b1;
        wait_drained();
      end
      no_idle = ($urandom_range(0, 4) == 0);
      n = $urandom_range(0, 99);
      if (n < 8) begin
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 8'h00, 8'h00);
        msgs_sent++;
      end else if (n < 18) begin
        // Noise: stray last flags and empty messages at any point of a chunk.
        repeat ($urandom_range(1, 4))
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 4) == 0), 8'h00, 8'h00);
      end else begin
        case ($urandom_range(0, 5))
          0: len = $urandom_range(1, CHUNK_BYTES - 1);
          1: len = CHUNK_BYTES;
          2: len = CHUNK_BYTES + 1;
          3: len = 2 * CHUNK_BYTES;
          4: len = $urandom_range(CHUNK_BYTES + 2, 35);
          default: len = $urandom_range(1, 3);
        endcase
        // Now and then a message is cut off by an empty message instead of last.
        cut = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++)
          send_item(8'($urandom_range(0, 255)), (k == len - 1) && !cut, 1'b0, 8'h00, 8'h00);
        if (cut)
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 8'h00, 8'h00);
        msgs_sent++;
      end
    end
    wait_drained();

    if (frame_exp_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, frame_exp_q.size());
    end
    $display("Sent %0d input items in about %0d messages; checked %0d output items in %0d frames.",
             items_sent, msgs_sent + 4, bytes_seen, frames_seen);
    $display("Output held off %0d time(s) for %0d cycles; %0d mismatches.",
             holds_done, HOLD_CYCLES, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mcf_pkg.sv
hdl/mcf_datapath.sv
hdl/mcf_ctrl.sv
hdl/message_chunk_framer.sv
sim/tb_message_chunk_framer.sv
